// ===== rtl/adx_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adx_pkg
// Shared types and constants for the ADX 4-bit ADPCM frame decoder.
// ----------------------------------------------------------------------------
package adx_pkg;

  localparam int MAX_CHANNELS   = 2;
  localparam int CH_W           = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int FRAME_BYTES    = 18;
  localparam int FRAME_SAMPLES  = 32;
  localparam int PRED_SHIFT     = 12;
  localparam int BIF_W          = 5;

  localparam logic [1:0] REG_COEF_ONE    = 2'd0;
  localparam logic [1:0] REG_COEF_TWO    = 2'd1;
  localparam logic [1:0] REG_CHANNELS    = 2'd2;
  localparam logic [1:0] REG_TOTAL_COUNT = 2'd3;

  localparam logic signed [21:0] PCM_MAX = 22'sd32767;
  localparam logic signed [21:0] PCM_MIN = -22'sd32768;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_ADD,
    ST_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic load;
    logic mul;
    logic add;
    logic out_load;
    logic next_sample;
    logic advance;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_scale;
    logic emit_cur;
    logic second;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/adx_adpcm_frame_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adx_adpcm_frame_decoder
// ADX 4-bit ADPCM decoder, one payload byte per input word.
// ----------------------------------------------------------------------------
// channel   dir  handshake          payload
// s_        in   s_tvalid/s_tready  tdata: payload_byte; tuser: stream_start
// m_        out  m_tvalid/m_tready  tdata: pcm_sample, sample_position;
//                                   tuser: sample_channel; tlast: last_of_byte
// cfg_      in   cfg_valid/cfg_ready index 0..3, 32-bit data
//
// Scale bytes are accepted and loaded only. A nibble byte is accepted and
// loaded, then each sample gets a multiply step and an add/saturate step,
// then an output load if it is emitted (position below total count), which
// waits on m_tready. Reset (rst, synchronous) clears histories, frame
// position and coefficients and sets channel and total counts to 1.
// Input is taken while a finished word still waits at the output.
// ----------------------------------------------------------------------------
module adx_adpcm_frame_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] payload_byte
  input  logic [0:0]  s_tuser,   // [0] stream_start
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [15:0] pcm_sample, [47:16] sample_position
  output logic [0:0]  m_tuser,   // [0] sample_channel
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import adx_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  adx_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  adx_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_byte      (s_tdata),
    .in_start     (s_tuser[0]),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .out_sample   (m_tdata[15:0]),
    .out_channel  (m_tuser[0]),
    .out_position (m_tdata[47:16]),
    .out_last     (m_tlast)
  );

endmodule

// ===== rtl/adx_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adx_ctrl
// Sequencer: takes a byte, runs two multiply/add passes for nibble bytes.
// ----------------------------------------------------------------------------
module adx_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  adx_pkg::status_t status,
  output adx_pkg::cmd_t    cmd
);
  import adx_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.load = 1'b1;
        if (status.is_scale) begin
          cmd.advance = 1'b1;
          state_next  = ST_IDLE;
        end else begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_ADD;
      end
      ST_ADD: begin
        cmd.add = 1'b1;
        if (status.emit_cur) begin
          state_next = ST_OUT;
        end else if (status.second) begin
          cmd.advance = 1'b1;
          state_next  = ST_IDLE;
        end else begin
          cmd.next_sample = 1'b1;
          state_next      = ST_MUL;
        end
      end
      ST_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          if (status.second) begin
            cmd.advance = 1'b1;
            state_next  = ST_IDLE;
          end else begin
            cmd.next_sample = 1'b1;
            state_next      = ST_MUL;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/adx_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adx_dp
// Datapath: config registers, frame position, per-channel history,
// prediction multiply/add with saturation and the output word register.
// ----------------------------------------------------------------------------
module adx_dp (
  input  logic             clk,
  input  logic             rst,
  input  adx_pkg::cmd_t    cmd,
  output adx_pkg::status_t status,
  input  logic             cfg_valid,
  input  logic [1:0]       cfg_index,
  input  logic [31:0]      cfg_data,
  input  logic [7:0]       in_byte,
  input  logic             in_start,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [15:0]      out_sample,
  output logic             out_channel,
  output logic [31:0]      out_position,
  output logic             out_last
);
  import adx_pkg::*;

  logic        [13:0]     coef_one;
  logic signed [12:0]     coef_two;
  logic        [1:0]      channel_count;
  logic        [31:0]     total_count;

  logic        [7:0]      byte_reg;
  logic        [BIF_W-1:0] bif;
  logic        [CH_W-1:0] ch;
  logic        [15:0]     scale;
  logic        [31:0]     base;
  logic signed [15:0]     prev_hist  [MAX_CHANNELS];
  logic signed [15:0]     older_hist [MAX_CHANNELS];

  logic        [31:0]     pos;
  logic        [31:0]     pos_inc;
  logic                   second;
  logic                   emit_cur;
  logic                   emit_nxt;

  logic signed [30:0]     prod_one;
  logic signed [28:0]     prod_two;
  logic signed [20:0]     prod_scale;
  logic signed [31:0]     acc;
  logic signed [19:0]     pred;
  logic signed [21:0]     sum;
  logic signed [15:0]     sat;
  logic signed [3:0]      nib;
  logic        [BIF_W-1:0] bif_m2;
  logic                   wrap_ch;
  logic                   out_free;

  assign out_free = !m_tvalid || m_tready;
  assign pos_inc  = pos + 32'd1;
  assign nib      = second ? $signed(byte_reg[3:0]) : $signed(byte_reg[7:4]);
  assign bif_m2   = bif - BIF_W'(2);
  // stereo when channel_count is 2 or 3
  assign wrap_ch  = (ch == CH_W'(MAX_CHANNELS - 1)) || !channel_count[1];

  assign acc  = 32'(prod_one) + 32'(prod_two);
  assign pred = acc[31:PRED_SHIFT];
  assign sum  = 22'(prod_scale) + 22'(pred);

  always_comb begin
    if (sum > PCM_MAX) begin
      sat = 16'sh7fff;
    end else if (sum < PCM_MIN) begin
      sat = -16'sh8000;
    end else begin
      sat = sum[15:0];
    end
  end

  assign status.is_scale = (bif < BIF_W'(2));
  assign status.emit_cur = emit_cur;
  assign status.second   = second;
  assign status.out_free = out_free;

  // config
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_one      <= '0;
      coef_two      <= '0;
      channel_count <= 2'd1;
      total_count   <= 32'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_COEF_ONE:    coef_one      <= cfg_data[13:0];
        REG_COEF_TWO:    coef_two      <= $signed(cfg_data[12:0]);
        REG_CHANNELS:    channel_count <= cfg_data[1:0];
        REG_TOTAL_COUNT: total_count   <= cfg_data;
        default: ;
      endcase
    end
  end

  // stream state
  always_ff @(posedge clk) begin
    if (rst) begin
      bif   <= '0;
      ch    <= '0;
      scale <= '0;
      base  <= '0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        prev_hist[i]  <= '0;
        older_hist[i] <= '0;
      end
    end else begin
      if (cmd.accept && in_start) begin
        bif   <= '0;
        ch    <= '0;
        scale <= '0;
        base  <= '0;
        for (int i = 0; i < MAX_CHANNELS; i++) begin
          prev_hist[i]  <= '0;
          older_hist[i] <= '0;
        end
      end
      if (cmd.load && bif == BIF_W'(0)) begin
        scale[15:8] <= byte_reg;
      end
      if (cmd.load && bif == BIF_W'(1)) begin
        scale[7:0] <= byte_reg;
      end
      if (cmd.add) begin
        older_hist[ch] <= prev_hist[ch];
        prev_hist[ch]  <= sat;
      end
      if (cmd.advance) begin
        if (bif == BIF_W'(FRAME_BYTES - 1)) begin
          bif <= '0;
          if (wrap_ch) begin
            ch   <= '0;
            base <= base + 32'(FRAME_SAMPLES);
          end else begin
            ch <= ch + CH_W'(1);
          end
        end else begin
          bif <= bif + BIF_W'(1);
        end
      end
    end
  end

  // per-byte working registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      byte_reg <= in_byte;
    end
    if (cmd.load) begin
      pos    <= base + {27'd0, bif_m2[3:0], 1'b0};
      second <= 1'b0;
    end
    if (cmd.next_sample) begin
      pos    <= pos_inc;
      second <= 1'b1;
    end
    if (cmd.mul) begin
      prod_one   <= $signed({1'b0, coef_one}) * prev_hist[ch];
      prod_two   <= coef_two * older_hist[ch];
      prod_scale <= $signed({1'b0, scale}) * nib;
      emit_cur   <= (pos < total_count);
      emit_nxt   <= (pos_inc < total_count);
    end
    if (cmd.out_load) begin
      out_sample   <= sat;
      out_channel  <= ch;
      out_position <= pos;
      out_last     <= second || !emit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> out_free)
    else $error("output word overwritten before taken");

  a_bif_range: assert property (@(posedge clk) disable iff (rst)
    bif <= BIF_W'(FRAME_BYTES - 1))
    else $error("byte position past end of frame");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> m_tvalid)
    else $error("loaded word not presented");

  a_mul_add: assert property (@(posedge clk) disable iff (rst)
    cmd.mul |=> cmd.add)
    else $error("product not consumed");

endmodule
